>>> rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Shared concurrent assertion macros, clocked on a rising edge and disabled
// while the active-low asynchronous reset is asserted.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// property must hold at every clock edge out of reset
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
		else $error(msg);

// consequent must hold in the cycle after the antecedent
`define ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/rcsf_pkg.sv
// ----------------------------------------------------------------------------
// rcsf_pkg
// Types and fixed constants shared by the frame decoder controller, datapath
// and top level.
// ----------------------------------------------------------------------------
package rcsf_pkg;

	// frame start marker
	localparam logic [7:0] START_BYTE = 8'hA4;

	// configuration register indexes
	localparam logic [1:0] REG_SWITCH_THRESHOLD = 2'd0;
	localparam logic [1:0] REG_PWM_BASE         = 2'd1;
	localparam logic [1:0] REG_PWM_SPAN         = 2'd2;

	// configuration reset values
	localparam logic [15:0] THRESHOLD_RESET = 16'd42130;
	localparam logic [6:0]  PWM_BASE_RESET  = 7'd57;
	localparam logic [5:0]  PWM_SPAN_RESET  = 6'd19;

	// slider scaling: ceil(1400 * raw / 65535)
	localparam logic [26:0] SLIDER_SCALE = 27'd1400;
	localparam logic [26:0] CEIL_BIAS    = 27'd65534;
	localparam logic [16:0] RAW_FULL     = 17'd65535;

	// pwm offset and divisor
	localparam logic signed [11:0] PWM_OFFSET = 12'sd300;
	localparam logic [16:0]        PWM_DIV    = 17'd800;

	// reciprocal of 25, scaled by 2^17, exact for quotients below 1747
	localparam logic [25:0] RECIP_25 = 26'd5243;

	// pwm output limits
	localparam logic signed [9:0] PWM_MAX = 10'sd127;
	localparam logic signed [9:0] PWM_MIN = -10'sd128;

	// controller states
	typedef enum logic [2:0] {
		ST_RECV,
		ST_SCALE,
		ST_CEIL,
		ST_GAIN,
		ST_DIVIDE,
		ST_EMIT
	} state_t;

	// controller to datapath commands
	typedef struct packed {
		logic take_byte;
		logic scale;
		logic ceil_fix;
		logic gain;
		logic divide;
		logic emit;
	} cmd_t;

	// datapath to controller status
	typedef struct packed {
		logic last_byte;
	} status_t;

endpackage

>>> rtl/rcsf_ctrl.sv
// ----------------------------------------------------------------------------
// rcsf_ctrl
// Sequencer for the frame decoder: takes bytes while a frame is received,
// then steps the datapath through the pwm arithmetic and loads the result.
// ----------------------------------------------------------------------------
module rcsf_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	output logic              out_valid,
	input  logic              out_ready,
	input  rcsf_pkg::status_t status,
	output rcsf_pkg::cmd_t    cmd
);

	rcsf_pkg::state_t state_q;
	rcsf_pkg::state_t state_next;
	logic             out_valid_q;

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rcsf_pkg::ST_RECV;
		end else begin
			state_q <= state_next;
		end
	end

	// next state and commands
	always_comb begin
		state_next = state_q;
		cmd        = '0;
		case (state_q)
			rcsf_pkg::ST_RECV: begin
				if (in_valid) begin
					cmd.take_byte = 1'b1;
					if (status.last_byte) begin
						state_next = rcsf_pkg::ST_SCALE;
					end
				end
			end
			rcsf_pkg::ST_SCALE: begin
				cmd.scale  = 1'b1;
				state_next = rcsf_pkg::ST_CEIL;
			end
			rcsf_pkg::ST_CEIL: begin
				cmd.ceil_fix = 1'b1;
				state_next   = rcsf_pkg::ST_GAIN;
			end
			rcsf_pkg::ST_GAIN: begin
				cmd.gain   = 1'b1;
				state_next = rcsf_pkg::ST_DIVIDE;
			end
			rcsf_pkg::ST_DIVIDE: begin
				cmd.divide = 1'b1;
				state_next = rcsf_pkg::ST_EMIT;
			end
			rcsf_pkg::ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					cmd.emit   = 1'b1;
					state_next = rcsf_pkg::ST_RECV;
				end
			end
			default: begin
				state_next = rcsf_pkg::ST_RECV;
			end
		endcase
	end

	// output word held until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.emit) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	assign in_ready  = (state_q == rcsf_pkg::ST_RECV);
	assign out_valid = out_valid_q;

endmodule

>>> rtl/rcsf_datapath.sv
// ----------------------------------------------------------------------------
// rcsf_datapath
// Frame parser, channel capture, configuration registers and the multi-step
// switch and pitch pwm arithmetic, with the output word register.
// ----------------------------------------------------------------------------
module rcsf_datapath #(
	parameter int CHANNEL_COUNT  = 14,
	parameter int SWITCH_CHANNEL = 6,
	parameter int SLIDER_CHANNEL = 7
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rcsf_pkg::cmd_t       cmd,
	output rcsf_pkg::status_t    status,
	input  logic [7:0]           rx_byte,
	input  logic                 cfg_we,
	input  logic [1:0]           cfg_index,
	input  logic [15:0]          cfg_data,
	output logic                 switch_on,
	output logic                 switch_changed,
	output logic signed [7:0]    pitch_pwm,
	output logic                 pwm_changed,
	output logic [15:0]          switch_raw,
	output logic [15:0]          slider_raw
);

	// frame buffer length and channel byte positions
	localparam int BufLen  = 4 * CHANNEL_COUNT + 7;
	localparam int CountW  = $clog2(BufLen + 1);
	localparam int SwHiPos = 4 + 4 * SWITCH_CHANNEL + 2;
	localparam int SwLoPos = 4 + 4 * SWITCH_CHANNEL + 3;
	localparam int SlHiPos = 4 + 4 * SLIDER_CHANNEL + 2;
	localparam int SlLoPos = 4 + 4 * SLIDER_CHANNEL + 3;
	localparam bit SwHiOk  = SwHiPos < BufLen;
	localparam bit SwLoOk  = SwLoPos < BufLen;
	localparam bit SlHiOk  = SlHiPos < BufLen;
	localparam bit SlLoOk  = SlLoPos < BufLen;

	logic [CountW-1:0]   count_q;
	logic [7:0]          len_q;
	logic [15:0]         switch_value_q;
	logic [15:0]         slider_value_q;
	logic [15:0]         threshold_q;
	logic [6:0]          base_q;
	logic [5:0]          span_q;
	logic                last_switch_q;
	logic signed [7:0]   last_pwm_q;
	logic [26:0]         scaled_q;
	logic [10:0]         ceil_q;
	logic signed [18:0]  num_q;
	logic                neg_q;
	logic [7:0]          quot_q;
	logic                switch_on_q;
	logic                switch_changed_q;
	logic signed [7:0]   pitch_pwm_q;
	logic                pwm_changed_q;
	logic [15:0]         switch_raw_q;
	logic [15:0]         slider_raw_q;

	logic                too_long;
	logic                hit_end;
	logic [10:0]         coarse_q;
	logic [16:0]         rem;
	logic signed [11:0]  offset;
	logic signed [18:0]  span_s;
	logic signed [18:0]  offset_s;
	logic [16:0]         base_x800;
	logic [17:0]         mag;
	logic [25:0]         recip_prod;
	logic signed [9:0]   pwm_wide;
	logic signed [7:0]   pwm_sat;
	logic                sw_now;

	// frame position compares
	assign too_long = ({1'b0, rx_byte} + 9'd3) > 9'(BufLen);
	assign hit_end  = (9'(count_q) + 9'd1) == ({1'b0, len_q} + 9'd3);
	assign status.last_byte = (count_q >= CountW'(2)) && hit_end;

	// byte counter and stated length
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
			len_q   <= '0;
		end else if (cmd.take_byte) begin
			if (count_q == '0) begin
				if (rx_byte == rcsf_pkg::START_BYTE) begin
					count_q <= CountW'(1);
				end
			end else if (count_q == CountW'(1)) begin
				len_q <= rx_byte;
				if (too_long) begin
					count_q <= '0;
				end else begin
					count_q <= CountW'(2);
				end
			end else if (hit_end) begin
				count_q <= '0;
			end else begin
				count_q <= count_q + CountW'(1);
			end
		end
	end

	// channel capture, big endian
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			switch_value_q <= '0;
			slider_value_q <= '0;
		end else if (cmd.take_byte && (count_q != '0)) begin
			if (SwHiOk && (count_q == CountW'(SwHiPos))) begin
				switch_value_q[15:8] <= rx_byte;
			end
			if (SwLoOk && (count_q == CountW'(SwLoPos))) begin
				switch_value_q[7:0] <= rx_byte;
			end
			if (SlHiOk && (count_q == CountW'(SlHiPos))) begin
				slider_value_q[15:8] <= rx_byte;
			end
			if (SlLoOk && (count_q == CountW'(SlLoPos))) begin
				slider_value_q[7:0] <= rx_byte;
			end
		end
	end

	// configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= rcsf_pkg::THRESHOLD_RESET;
			base_q      <= rcsf_pkg::PWM_BASE_RESET;
			span_q      <= rcsf_pkg::PWM_SPAN_RESET;
		end else if (cfg_we) begin
			case (cfg_index)
				rcsf_pkg::REG_SWITCH_THRESHOLD: threshold_q <= cfg_data;
				rcsf_pkg::REG_PWM_BASE:         base_q      <= cfg_data[6:0];
				rcsf_pkg::REG_PWM_SPAN:         span_q      <= cfg_data[5:0];
				default: ;
			endcase
		end
	end

	// ceiling of slider * 1400 / 65535: n = q*65536 + lo = q*65535 + (lo + q)
	assign coarse_q = scaled_q[26:16];
	assign rem      = {1'b0, scaled_q[15:0]} + 17'(coarse_q);

	// gain step operands
	assign offset    = $signed({1'b0, ceil_q}) - rcsf_pkg::PWM_OFFSET;
	assign span_s    = $signed({13'd0, span_q});
	assign offset_s  = 19'(offset);
	assign base_x800 = 17'(base_q) * rcsf_pkg::PWM_DIV;

	// divide by 800: drop 5 bits, then reciprocal multiply by 1/25
	assign mag        = num_q[18] ? 18'(-num_q) : 18'(num_q);
	assign recip_prod = 26'(mag[17:5]) * rcsf_pkg::RECIP_25;

	// sign restore and saturation
	assign pwm_wide = neg_q ? -$signed({2'b00, quot_q}) : $signed({2'b00, quot_q});
	always_comb begin
		if (pwm_wide > rcsf_pkg::PWM_MAX) begin
			pwm_sat = 8'(rcsf_pkg::PWM_MAX);
		end else if (pwm_wide < rcsf_pkg::PWM_MIN) begin
			pwm_sat = 8'(rcsf_pkg::PWM_MIN);
		end else begin
			pwm_sat = 8'(pwm_wide);
		end
	end

	assign sw_now = switch_value_q < threshold_q;

	// arithmetic pipeline registers, one step per command
	always_ff @(posedge clk) begin
		if (cmd.scale) begin
			scaled_q <= 27'(slider_value_q) * rcsf_pkg::SLIDER_SCALE + rcsf_pkg::CEIL_BIAS;
		end
		if (cmd.ceil_fix) begin
			ceil_q <= coarse_q + 11'(rem >= rcsf_pkg::RAW_FULL);
		end
		if (cmd.gain) begin
			num_q <= $signed({2'b00, base_x800}) + span_s * offset_s;
		end
		if (cmd.divide) begin
			neg_q  <= num_q[18];
			quot_q <= recip_prod[24:17];
		end
	end

	// last frame history
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_switch_q <= 1'b0;
			last_pwm_q    <= '0;
		end else if (cmd.emit) begin
			last_switch_q <= sw_now;
			last_pwm_q    <= pwm_sat;
		end
	end

	// output word register
	always_ff @(posedge clk) begin
		if (cmd.emit) begin
			switch_on_q      <= sw_now;
			switch_changed_q <= sw_now != last_switch_q;
			pitch_pwm_q      <= pwm_sat;
			pwm_changed_q    <= pwm_sat != last_pwm_q;
			switch_raw_q     <= switch_value_q;
			slider_raw_q     <= slider_value_q;
		end
	end

	assign switch_on      = switch_on_q;
	assign switch_changed = switch_changed_q;
	assign pitch_pwm      = pitch_pwm_q;
	assign pwm_changed    = pwm_changed_q;
	assign switch_raw     = switch_raw_q;
	assign slider_raw     = slider_raw_q;

endmodule

>>> rtl/rc_serial_frame_to_switch_and_pwm.sv
// ----------------------------------------------------------------------------
// rc_serial_frame_to_switch_and_pwm
// Serial remote-control frame decoder producing a switch state and a pitch
// pwm value, each with a changed flag, once per received frame.
// ----------------------------------------------------------------------------
// Received bytes are taken one per clock while a frame is coming in; bytes
// outside a frame other than the start byte are dropped. After the last byte
// of a frame the input stalls while the controller steps the shared datapath
// through the slider scaling multiply, the ceiling correction, the gain
// multiply, the divide by 800 and the load of the output word register. The
// final step also waits while the previous output word has not yet been taken.
// A frame whose stated length does not fit the 4*CHANNEL_COUNT+7 byte buffer
// is abandoned without a result. The CRC is not checked. Configuration writes
// are taken at any time and must be issued only while no frame is in flight.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module rc_serial_frame_to_switch_and_pwm #(
	parameter int CHANNEL_COUNT  = 14,
	parameter int SWITCH_CHANNEL = 6,
	parameter int SLIDER_CHANNEL = 7
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  logic [7:0]        rx_byte,
	output logic              out_valid,
	input  logic              out_ready,
	output logic              switch_on,
	output logic              switch_changed,
	output logic signed [7:0] pitch_pwm,
	output logic              pwm_changed,
	output logic [15:0]       switch_raw,
	output logic [15:0]       slider_raw,
	input  logic              cfg_valid,
	output logic              cfg_ready,
	input  logic [1:0]        cfg_index,
	input  logic [15:0]       cfg_data
);

	rcsf_pkg::cmd_t    cmd;
	rcsf_pkg::status_t status;

	// configuration writes never stall
	assign cfg_ready = 1'b1;

	// controller
	rcsf_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.status    (status),
		.cmd       (cmd)
	);

	// datapath
	rcsf_datapath #(
		.CHANNEL_COUNT  (CHANNEL_COUNT),
		.SWITCH_CHANNEL (SWITCH_CHANNEL),
		.SLIDER_CHANNEL (SLIDER_CHANNEL)
	) u_datapath (
		.clk            (clk),
		.arst_n         (arst_n),
		.cmd            (cmd),
		.status         (status),
		.rx_byte        (rx_byte),
		.cfg_we         (cfg_valid && cfg_ready),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.switch_on      (switch_on),
		.switch_changed (switch_changed),
		.pitch_pwm      (pitch_pwm),
		.pwm_changed    (pwm_changed),
		.switch_raw     (switch_raw),
		.slider_raw     (slider_raw)
	);

	// checks
	`ASSERT_ALWAYS(a_cmd_onehot, clk, arst_n, $onehot0(cmd), "more than one datapath command")
	`ASSERT_NEXT(a_stall_after_frame, clk, arst_n, in_valid && in_ready && status.last_byte, !in_ready, "input not stalled after last byte of frame")
	`ASSERT_NEXT(a_emit_valid, clk, arst_n, cmd.emit, out_valid, "output word loaded without valid")
	`ASSERT_ALWAYS(a_no_byte_while_busy, clk, arst_n, !(cmd.take_byte && (cmd.scale || cmd.emit)), "byte taken during arithmetic")

endmodule

>>> dv/rc_serial_frame_to_switch_and_pwm_test.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rc_serial_frame_to_switch_and_pwm_test
// Streams serial bytes into the frame decoder: a few hand-picked sequences,
// then well-formed frames with random channel data mixed with noise,
// truncated frames and oversized lengths. A shadow decoder predicts every
// output word, and each word that comes out is compared field by field.
// Valid and ready idle at random, and the output side holds off once for a
// long stretch. Register settings change between phases, extremes included.
// ----------------------------------------------------------------------------
module rc_serial_frame_to_switch_and_pwm_test;

	localparam int CHANNEL_COUNT   = 14;
	localparam int SWITCH_CHANNEL  = 6;
	localparam int SLIDER_CHANNEL  = 7;
	localparam int FRAME_BYTES_MAX = 4 * CHANNEL_COUNT + 7;
	localparam int SW_HI_POS       = 4 + 4 * SWITCH_CHANNEL + 2;
	localparam int SW_LO_POS       = 4 + 4 * SWITCH_CHANNEL + 3;
	localparam int SL_HI_POS       = 4 + 4 * SLIDER_CHANNEL + 2;
	localparam int SL_LO_POS       = 4 + 4 * SLIDER_CHANNEL + 3;
	localparam int LONGEST_LEN     = FRAME_BYTES_MAX - 3;
	localparam int SETTLE_CYCLES   = 24;
	localparam int DRAIN_LIMIT     = 20000;
	localparam int TIMEOUT_NS      = 2_000_000;

	// one decoded output word
	typedef struct {
		logic        switch_on;
		logic        switch_changed;
		logic [7:0]  pitch_pwm;
		logic        pwm_changed;
		logic [15:0] switch_raw;
		logic [15:0] slider_raw;
	} word_t;

	// shadow decoder: byte parser, channel capture and switch/pwm scaling
	class frame_decoder_shadow;
		logic [15:0] threshold;
		logic [6:0]  base;
		logic [5:0]  span;
		int          pos;
		logic [7:0]  stated_len;
		logic [15:0] switch_value;
		logic [15:0] slider_value;
		logic        last_switch;
		logic [7:0]  last_pwm;
		word_t       expected_words[$];
		int          words_predicted;
		int          errors;

		function new();
			threshold       = rcsf_pkg::THRESHOLD_RESET;
			base            = rcsf_pkg::PWM_BASE_RESET;
			span            = rcsf_pkg::PWM_SPAN_RESET;
			pos             = 0;
			stated_len      = 8'd0;
			switch_value    = 16'd0;
			slider_value    = 16'd0;
			last_switch     = 1'b0;
			last_pwm        = 8'd0;
			words_predicted = 0;
			errors          = 0;
		endfunction

		function void write_reg(logic [1:0] idx, logic [15:0] data);
			case (idx)
				rcsf_pkg::REG_SWITCH_THRESHOLD: threshold = data;
				rcsf_pkg::REG_PWM_BASE:         base      = data[6:0];
				rcsf_pkg::REG_PWM_SPAN:         span      = data[5:0];
				default: ;
			endcase
		endfunction

		function bit in_frame();
			return pos != 0;
		endfunction

		// base + span * (ceil(1400 * raw / 65535) - 300) / 800, saturated
		function logic [7:0] scaled_pitch(logic [15:0] raw);
			int ceil_scaled;
			int offset;
			int num;
			int value;
			ceil_scaled = (1400 * int'(raw) + 65534) / 65535;
			offset      = ceil_scaled - 300;
			num         = 800 * int'(base) + int'(span) * offset;
			value       = num / 800;
			if (value > 127)
				value = 127;
			if (value < -128)
				value = -128;
			return value[7:0];
		endfunction

		// accepted byte: advance the parser, predict a word at frame end
		function void note_byte(logic [7:0] b);
			word_t w;
			if (pos == 0) begin
				if (b == rcsf_pkg::START_BYTE)
					pos = 1;
				return;
			end
			if (pos == SW_HI_POS && SW_HI_POS < FRAME_BYTES_MAX)
				switch_value[15:8] = b;
			if (pos == SW_LO_POS && SW_LO_POS < FRAME_BYTES_MAX)
				switch_value[7:0] = b;
			if (pos == SL_HI_POS && SL_HI_POS < FRAME_BYTES_MAX)
				slider_value[15:8] = b;
			if (pos == SL_LO_POS && SL_LO_POS < FRAME_BYTES_MAX)
				slider_value[7:0] = b;
			if (pos == 1) begin
				stated_len = b;
				// length that cannot fit the buffer drops the frame
				if (int'(b) + 3 > FRAME_BYTES_MAX) begin
					pos = 0;
					return;
				end
			end
			pos++;
			if (pos != int'(stated_len) + 3)
				return;
			pos              = 0;
			w.switch_on      = switch_value < threshold;
			w.switch_changed = w.switch_on != last_switch;
			w.pitch_pwm      = scaled_pitch(slider_value);
			w.pwm_changed    = w.pitch_pwm != last_pwm;
			w.switch_raw     = switch_value;
			w.slider_raw     = slider_value;
			last_switch      = w.switch_on;
			last_pwm         = w.pitch_pwm;
			expected_words.push_back(w);
			words_predicted++;
		endfunction

		function void compare_field(string name, int want, int seen);
			if (want != seen) begin
				$error("%s: expected %0d, got %0d", name, want, seen);
				errors++;
			end
		endfunction

		// output word taken: compare with the oldest prediction
		function void check_word(word_t got);
			word_t want;
			if (expected_words.size() == 0) begin
				$error("output word with none predicted: switch_raw %0d slider_raw %0d",
					got.switch_raw, got.slider_raw);
				errors++;
				return;
			end
			want = expected_words.pop_front();
			compare_field("switch_on", int'(want.switch_on), int'(got.switch_on));
			compare_field("switch_changed", int'(want.switch_changed),
				int'(got.switch_changed));
			compare_field("pitch_pwm", int'($signed(want.pitch_pwm)),
				int'($signed(got.pitch_pwm)));
			compare_field("pwm_changed", int'(want.pwm_changed), int'(got.pwm_changed));
			compare_field("switch_raw", int'(want.switch_raw), int'(got.switch_raw));
			compare_field("slider_raw", int'(want.slider_raw), int'(got.slider_raw));
		endfunction
	endclass

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              in_valid = 1'b0;
	logic              in_ready;
	logic [7:0]        rx_byte = 8'd0;
	logic              out_valid;
	logic              out_ready = 1'b0;
	logic              switch_on;
	logic              switch_changed;
	logic signed [7:0] pitch_pwm;
	logic              pwm_changed;
	logic [15:0]       switch_raw;
	logic [15:0]       slider_raw;
	logic              cfg_valid = 1'b0;
	logic              cfg_ready;
	logic [1:0]        cfg_index = 2'd0;
	logic [15:0]       cfg_data = 16'd0;

	frame_decoder_shadow shadow = new();
	int tx_idle_pct    = 0;
	int rx_idle_pct    = 0;
	int rx_hold_cycles = 0;
	int bytes_sent     = 0;

	rc_serial_frame_to_switch_and_pwm #(
		.CHANNEL_COUNT (CHANNEL_COUNT),
		.SWITCH_CHANNEL(SWITCH_CHANNEL),
		.SLIDER_CHANNEL(SLIDER_CHANNEL)
	) DUT (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_ready      (in_ready),
		.rx_byte       (rx_byte),
		.out_valid     (out_valid),
		.out_ready     (out_ready),
		.switch_on     (switch_on),
		.switch_changed(switch_changed),
		.pitch_pwm     (pitch_pwm),
		.pwm_changed   (pwm_changed),
		.switch_raw    (switch_raw),
		.slider_raw    (slider_raw),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_index     (cfg_index),
		.cfg_data      (cfg_data)
	);

	// 125 MHz clock
	initial begin
		forever #4 clk = ~clk;
	end

	// hard stop in case the block hangs
	initial begin
		#(TIMEOUT_NS);
		$display("CHECKS FAILED");
		$finish;
	end

	// output side: take words, random stalls, one long hold on request
	initial begin : receiver
		word_t got;
		int    stall_left;
		stall_left = 0;
		@(posedge arst_n);
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				got.switch_on      = switch_on;
				got.switch_changed = switch_changed;
				got.pitch_pwm      = pitch_pwm;
				got.pwm_changed    = pwm_changed;
				got.switch_raw     = switch_raw;
				got.slider_raw     = slider_raw;
				shadow.check_word(got);
			end
			if (rx_hold_cycles > 0) begin
				rx_hold_cycles--;
				out_ready <= 1'b0;
			end else if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else if ($urandom_range(0, 99) < rx_idle_pct) begin
				stall_left = $urandom_range(0, 5);
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	// offer one byte, optionally after an idle burst, and wait until it is taken
	task automatic send_byte(input logic [7:0] value);
		int gap;
		if ($urandom_range(0, 99) < tx_idle_pct) begin
			gap = $urandom_range(1, 6);
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		rx_byte  <= value;
		do @(posedge clk); while (!in_ready);
		shadow.note_byte(value);
		bytes_sent++;
	endtask

	task automatic write_reg(input logic [1:0] idx, input logic [15:0] data);
		cfg_valid <= 1'b1;
		cfg_index <= idx;
		cfg_data  <= data;
		do @(posedge clk); while (!cfg_ready);
		shadow.write_reg(idx, data);
	endtask

	task automatic set_config(input logic [15:0] threshold, input logic [6:0] base,
			input logic [5:0] span);
		write_reg(rcsf_pkg::REG_SWITCH_THRESHOLD, threshold);
		write_reg(rcsf_pkg::REG_PWM_BASE, {9'd0, base});
		write_reg(rcsf_pkg::REG_PWM_SPAN, {10'd0, span});
		cfg_valid <= 1'b0;
	endtask

	// random register settings
	task automatic set_random_config();
		set_config(16'($urandom_range(0, 65535)), 7'($urandom_range(0, 127)),
			6'($urandom_range(0, 63)));
	endtask

	// drop valid, wait out all predicted words, then let the datapath settle
	task automatic wait_quiet();
		in_valid <= 1'b0;
		@(posedge clk);
		while (shadow.expected_words.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// pad out any frame left open so the parser is back to idle
	task automatic finish_frame();
		while (shadow.in_frame())
			send_byte(8'($urandom_range(0, 255)));
	endtask

	// raw channel value biased to the edges and the switch threshold
	function automatic logic [15:0] pick_raw();
		case ($urandom_range(0, 7))
			0:       return 16'h0000;
			1:       return 16'hFFFF;
			2:       return shadow.threshold - 16'd1;
			3:       return shadow.threshold;
			default: return 16'($urandom_range(0, 65535));
		endcase
	endfunction

	// one frame: mostly well formed, sometimes short, cut off or oversized
	task automatic send_frame();
		int         len;
		int         total;
		int         pick;
		logic [15:0] sw;
		logic [15:0] sl;
		logic [7:0]  b;
		pick = $urandom_range(0, 99);
		if (pick < 6)
			len = $urandom_range(LONGEST_LEN + 1, 255);
		else if (pick < 18)
			len = $urandom_range(0, SL_LO_POS - 3);
		else if (pick < 26)
			len = LONGEST_LEN;
		else
			len = $urandom_range(SL_LO_POS - 2, LONGEST_LEN - 1);
		sw    = pick_raw();
		sl    = pick_raw();
		total = (len > LONGEST_LEN) ? 2 : len + 3;
		if (total > 2 && $urandom_range(0, 19) == 0)
			total = $urandom_range(2, total - 1);
		for (int p = 0; p < total; p++) begin
			case (p)
				0:         b = rcsf_pkg::START_BYTE;
				1:         b = len[7:0];
				SW_HI_POS: b = sw[15:8];
				SW_LO_POS: b = sw[7:0];
				SL_HI_POS: b = sl[15:8];
				SL_LO_POS: b = sl[7:0];
				default:   b = ($urandom_range(0, 15) == 0) ? rcsf_pkg::START_BYTE
						: 8'($urandom_range(0, 255));
			endcase
			send_byte(b);
		end
	endtask

	// random traffic until enough bytes and words, then back to idle
	task automatic run_phase(input int min_bytes, input int min_words);
		int first_byte;
		int first_word;
		first_byte = bytes_sent;
		first_word = shadow.words_predicted;
		while (bytes_sent - first_byte < min_bytes
				|| shadow.words_predicted - first_word < min_words) begin
			if ($urandom_range(0, 99) < 8)
				send_byte(8'($urandom_range(0, 255)));
			else
				send_frame();
		end
		finish_frame();
		wait_quiet();
	endtask

	initial begin : stimulus
		int i;
		repeat (3) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// bytes outside a frame are dropped
		send_byte(8'h00);
		send_byte(8'hFF);
		send_byte(8'h5A);
		// one past the longest length, and the largest length byte
		send_byte(rcsf_pkg::START_BYTE);
		send_byte(8'(LONGEST_LEN + 1));
		send_byte(rcsf_pkg::START_BYTE);
		send_byte(8'hFF);
		// shortest frame, start byte carried as data
		send_byte(rcsf_pkg::START_BYTE);
		send_byte(8'd0);
		send_byte(rcsf_pkg::START_BYTE);
		// short frame that never reaches the channels
		send_byte(rcsf_pkg::START_BYTE);
		send_byte(8'd1);
		send_byte(8'h12);
		send_byte(8'h34);
		wait_quiet();

		// reset settings, output held off long enough to back up the input
		tx_idle_pct    = 25;
		rx_idle_pct    = 25;
		rx_hold_cycles = 300;
		run_phase(200, 10);

		// all registers at their low end
		set_config(16'h0000, 7'd0, 6'd0);
		run_phase(150, 10);

		// all registers at their high end, no idling
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_config(16'hFFFF, 7'd127, 6'd63);
		run_phase(150, 10);

		// random settings, sender mostly idle
		tx_idle_pct = 40;
		rx_idle_pct = 10;
		set_random_config();
		run_phase(150, 10);

		// random settings, receiver mostly idle
		tx_idle_pct = 10;
		rx_idle_pct = 40;
		set_random_config();
		run_phase(150, 10);

		// closing stretch at full rate
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		set_random_config();
		run_phase(150, 10);

		// final drain with a bound, then check nothing is left
		in_valid <= 1'b0;
		for (i = 0; i < DRAIN_LIMIT && shadow.expected_words.size() != 0; i++)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		if (shadow.expected_words.size() != 0) begin
			$error("%0d predicted words never came out", shadow.expected_words.size());
			shadow.errors++;
		end
		if (shadow.errors == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

endmodule
